// ===== rtl/bsrq_pkg.sv =====
// ----------------------------------------------------------------------------
// bsrq_pkg
// Shared widths, codes and controller/datapath interface types for the
// block-sum range query store.
// ----------------------------------------------------------------------------
package bsrq_pkg;

   localparam int IDX_W      = 8;
   localparam int VAL_W      = 32;
   localparam int LEN_W      = 9;
   localparam int CNT_W      = IDX_W + 1;
   localparam int IDX_SPAN   = 2 ** IDX_W;
   localparam int DEF_DEPTH  = 256;
   localparam int DEF_BLOCKS = 256;

   localparam logic [LEN_W-1:0] LEN_RESET = 9'd16;

   localparam logic KIND_UPDATE = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   typedef struct packed {
      logic load_item;
      logic div_step;
      logic upd_read;
      logic upd_write;
      logic walk_init;
      logic walk_rb;
      logic walk_step;
      logic clr_step;
      logic clr_elem;
      logic csr_write;
      logic rsp_load;
   } bsrq_cmd_type;

   typedef struct packed {
      logic kind_query;
      logic div_last;
      logic walk_done;
      logic clr_last;
      logic rsp_full;
   } bsrq_status_type;

endpackage

// ===== rtl/bsrq_ram.sv =====
// ----------------------------------------------------------------------------
// bsrq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bsrq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bsrq_datapath.sv =====
// ----------------------------------------------------------------------------
// bsrq_datapath
// Element and block-sum stores, index divider, walk counters, accumulator
// and result register.
// ----------------------------------------------------------------------------
module bsrq_datapath #(
   parameter int DEPTH  = bsrq_pkg::DEF_DEPTH,
   parameter int BLOCKS = bsrq_pkg::DEF_BLOCKS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bsrq_pkg::bsrq_cmd_type              cmd,
   output bsrq_pkg::bsrq_status_type           status,
   input  logic                                req_kind,
   input  logic        [bsrq_pkg::IDX_W-1:0]   req_index,
   input  logic        [bsrq_pkg::IDX_W-1:0]   req_right_end,
   input  logic signed [bsrq_pkg::VAL_W-1:0]   req_value,
   input  logic        [bsrq_pkg::LEN_W-1:0]   csr_block_len,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic signed [bsrq_pkg::VAL_W-1:0]   rsp_sum
);

   import bsrq_pkg::*;

   // only the first IDX_SPAN elements and blocks can ever be addressed
   localparam int EL_N  = (DEPTH < IDX_SPAN) ? DEPTH : IDX_SPAN;
   localparam int BK_N  = (BLOCKS < IDX_SPAN) ? BLOCKS : IDX_SPAN;
   localparam int MAX_N = (EL_N > BK_N) ? EL_N : BK_N;
   localparam int EA_W  = $clog2(EL_N);
   localparam int BA_W  = $clog2(BK_N);
   localparam int DC_W  = $clog2(IDX_W);
   localparam int SUM_W = CNT_W + 1;

   logic [LEN_W-1:0] len_ff, len_in;
   logic             kind_ff;
   logic [IDX_W-1:0] idx_ff, right_ff;
   logic [VAL_W-1:0] value_ff;

   logic [IDX_W-1:0] num_ff, num_in, quo_ff, quo_in;
   logic [LEN_W-1:0] rem_ff, rem_in;
   logic [DC_W-1:0]  dcnt_ff, dcnt_in;

   logic [CNT_W-1:0] p_ff, p_in, pos_ff, pos_in, b_ff, b_in, lim_ff, lim_in;
   logic             mode_rb_ff, mode_rb_in;
   logic             rd_vld_ff, rd_vld_in, rd_src_blk_ff, rd_last_ff;
   logic [CNT_W-1:0] rd_blk_ff;
   logic [VAL_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0] clr_ff, clr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0] rsp_sum_ff;

   logic [LEN_W-1:0] eff_len, div_sh, div_rem_nx;
   logic             div_ge;
   logic [CNT_W-1:0] right_c;
   logic [SUM_W-1:0] jump;
   logic             walk_done, use_blk, issue, pos_wrap, idx_in_range;
   logic             clr_last, rb_wr, upd_blk, clr_blk;
   logic [VAL_W-1:0] rd_sel, acc_sum;

   logic             elem_we, blk_we;
   logic [EA_W-1:0]  elem_waddr, elem_raddr;
   logic [BA_W-1:0]  blk_waddr, blk_raddr;
   logic [VAL_W-1:0] elem_wdata, elem_rdata, blk_wdata, blk_rdata;

   assign eff_len = (len_ff == '0) ? LEN_W'(1) : len_ff;
   assign right_c = (CNT_W'(right_ff) >= CNT_W'(EL_N)) ? CNT_W'(EL_N - 1)
                                                       : CNT_W'(right_ff);
   assign idx_in_range = CNT_W'(idx_ff) < CNT_W'(EL_N);

   // restoring divider, one quotient bit per step
   assign div_sh     = LEN_W'({rem_ff[IDX_W-1:0], num_ff[IDX_W-1]});
   assign div_ge     = div_sh >= eff_len;
   assign div_rem_nx = div_ge ? (div_sh - eff_len) : div_sh;

   always_comb begin
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dcnt_in = dcnt_ff;
      if (cmd.load_item) begin
         num_in  = req_index;
         quo_in  = '0;
         rem_in  = '0;
         dcnt_in = '0;
      end else if (cmd.div_step) begin
         num_in  = {num_ff[IDX_W-2:0], 1'b0};
         quo_in  = {quo_ff[IDX_W-2:0], div_ge};
         rem_in  = div_rem_nx;
         dcnt_in = dcnt_ff + DC_W'(1);
      end
   end

   // walk: a whole block sum is taken only when the block lies strictly
   // before the right end's block; otherwise one element per step
   assign walk_done = p_ff > lim_ff;
   assign jump      = SUM_W'(p_ff) + SUM_W'(eff_len);
   assign use_blk   = !mode_rb_ff && (pos_ff == '0) && (jump <= SUM_W'(lim_ff))
                      && (b_ff < CNT_W'(BK_N));
   assign issue     = cmd.walk_step && !walk_done;
   assign pos_wrap  = (pos_ff + CNT_W'(1)) == CNT_W'(eff_len);

   always_comb begin
      p_in       = p_ff;
      pos_in     = pos_ff;
      b_in       = b_ff;
      lim_in     = lim_ff;
      mode_rb_in = mode_rb_ff;
      if (cmd.walk_init) begin
         mode_rb_in = cmd.walk_rb;
         if (cmd.walk_rb) begin
            p_in   = '0;
            pos_in = '0;
            b_in   = '0;
            lim_in = CNT_W'(EL_N - 1);
         end else begin
            p_in   = CNT_W'(idx_ff);
            pos_in = CNT_W'(rem_ff);
            b_in   = CNT_W'(quo_ff);
            lim_in = right_c;
         end
      end else if (issue) begin
         if (use_blk) begin
            p_in = CNT_W'(jump);
            b_in = b_ff + CNT_W'(1);
         end else begin
            p_in = p_ff + CNT_W'(1);
            if (pos_wrap) begin
               pos_in = '0;
               b_in   = b_ff + CNT_W'(1);
            end else begin
               pos_in = pos_ff + CNT_W'(1);
            end
         end
      end
   end

   assign rd_vld_in = issue;
   assign rd_sel    = rd_src_blk_ff ? blk_rdata : elem_rdata;
   assign acc_sum   = acc_ff + rd_sel;
   assign rb_wr     = rd_vld_ff && mode_rb_ff && rd_last_ff && (rd_blk_ff < CNT_W'(BK_N));

   always_comb begin
      acc_in = acc_ff;
      if (cmd.walk_init) begin
         acc_in = '0;
      end else if (rd_vld_ff) begin
         acc_in = (mode_rb_ff && rd_last_ff) ? '0 : acc_sum;
      end
   end

   // clearing sweep
   assign clr_last = clr_ff == CNT_W'(MAX_N - 1);
   assign clr_in   = !cmd.clr_step ? clr_ff : (clr_last ? '0 : clr_ff + CNT_W'(1));
   assign clr_blk  = cmd.clr_step && (clr_ff < CNT_W'(BK_N));
   assign upd_blk  = cmd.upd_write && idx_in_range && (CNT_W'(quo_ff) < CNT_W'(BK_N));

   // element store ports
   assign elem_we    = (cmd.clr_step && cmd.clr_elem && (clr_ff < CNT_W'(EL_N)))
                       || (cmd.upd_write && idx_in_range);
   assign elem_waddr = cmd.upd_write ? idx_ff[EA_W-1:0] : clr_ff[EA_W-1:0];
   assign elem_wdata = cmd.upd_write ? value_ff : '0;
   assign elem_raddr = cmd.upd_read ? idx_ff[EA_W-1:0] : p_ff[EA_W-1:0];

   // block-sum store ports
   assign blk_we    = upd_blk || rb_wr || clr_blk;
   assign blk_raddr = cmd.upd_read ? quo_ff[BA_W-1:0] : b_ff[BA_W-1:0];

   always_comb begin
      if (cmd.upd_write) begin
         blk_waddr = quo_ff[BA_W-1:0];
         blk_wdata = blk_rdata - elem_rdata + value_ff;
      end else if (rb_wr) begin
         blk_waddr = rd_blk_ff[BA_W-1:0];
         blk_wdata = acc_sum;
      end else begin
         blk_waddr = clr_ff[BA_W-1:0];
         blk_wdata = '0;
      end
   end

   bsrq_ram #(
      .WIDTH (VAL_W),
      .DEPTH (EL_N)
   ) u_elem_ram (
      .clock   (clock),
      .wr_en   (elem_we),
      .wr_addr (elem_waddr),
      .wr_data (elem_wdata),
      .rd_addr (elem_raddr),
      .rd_data (elem_rdata)
   );

   bsrq_ram #(
      .WIDTH (VAL_W),
      .DEPTH (BK_N)
   ) u_blk_ram (
      .clock   (clock),
      .wr_en   (blk_we),
      .wr_addr (blk_waddr),
      .wr_data (blk_wdata),
      .rd_addr (blk_raddr),
      .rd_data (blk_rdata)
   );

   assign len_in       = cmd.csr_write ? csr_block_len : len_ff;
   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= LEN_RESET;
         dcnt_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         mode_rb_ff   <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         dcnt_ff      <= dcnt_in;
         rd_vld_ff    <= rd_vld_in;
         mode_rb_ff   <= mode_rb_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         kind_ff  <= req_kind;
         idx_ff   <= req_index;
         right_ff <= req_right_end;
         value_ff <= req_value;
      end
      if (cmd.rsp_load) begin
         rsp_sum_ff <= acc_ff;
      end
      num_ff        <= num_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      p_ff          <= p_in;
      pos_ff        <= pos_in;
      b_ff          <= b_in;
      lim_ff        <= lim_in;
      acc_ff        <= acc_in;
      rd_src_blk_ff <= use_blk;
      rd_last_ff    <= pos_wrap || (p_ff == lim_ff);
      rd_blk_ff     <= b_ff;
   end

   assign status.kind_query = kind_ff == KIND_QUERY;
   assign status.div_last   = dcnt_ff == DC_W'(IDX_W - 1);
   assign status.walk_done  = walk_done;
   assign status.clr_last   = clr_last;
   assign status.rsp_full   = rsp_valid_ff && rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_sum   = rsp_sum_ff;

endmodule

// ===== rtl/bsrq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsrq_ctrl
// Sequencer for clearing, block-sum rebuild, updates and range queries.
// ----------------------------------------------------------------------------
module bsrq_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  bsrq_pkg::bsrq_status_type  status,
   output bsrq_pkg::bsrq_cmd_type     cmd
);

   import bsrq_pkg::*;

   typedef enum logic [9:0] {
      ST_CLR_ALL = 10'b00_0000_0001,
      ST_IDLE    = 10'b00_0000_0010,
      ST_DIV     = 10'b00_0000_0100,
      ST_UPD_RD  = 10'b00_0000_1000,
      ST_UPD_WR  = 10'b00_0001_0000,
      ST_Q_INIT  = 10'b00_0010_0000,
      ST_Q_WALK  = 10'b00_0100_0000,
      ST_FINISH  = 10'b00_1000_0000,
      ST_RB_CLR  = 10'b01_0000_0000,
      ST_RB_WALK = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      csr_ready = 1'b0;
      case (state_ff)
         ST_CLR_ALL: begin
            cmd.clr_step = 1'b1;
            cmd.clr_elem = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            csr_ready = 1'b1;
            req_stall = csr_valid;
            if (csr_valid) begin
               cmd.csr_write = 1'b1;
               state_in      = ST_RB_CLR;
            end else if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = status.kind_query ? ST_Q_INIT : ST_UPD_RD;
            end
         end
         ST_UPD_RD: begin
            cmd.upd_read = 1'b1;
            state_in     = ST_UPD_WR;
         end
         ST_UPD_WR: begin
            cmd.upd_write = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_Q_INIT: begin
            cmd.walk_init = 1'b1;
            state_in      = ST_Q_WALK;
         end
         ST_Q_WALK: begin
            cmd.walk_step = 1'b1;
            if (status.walk_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!status.rsp_full) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_RB_CLR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               cmd.walk_init = 1'b1;
               cmd.walk_rb   = 1'b1;
               state_in      = ST_RB_WALK;
            end
         end
         ST_RB_WALK: begin
            cmd.walk_step = 1'b1;
            if (status.walk_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLR_ALL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR_ALL;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/block_sum_range_query.sv =====
// ----------------------------------------------------------------------------
// block_sum_range_query
// Update: accept, 8-step index divider, read, write; no result.
// Query: accept, index divider, walk init, then one walk step per stored entry
// visited (partial elements at both ends plus whole block sums). One item at
// a time. After reset the element and block-sum stores are swept to zero; a
// block_len write rebuilds block sums (a block-sum sweep to zero, then a walk
// over every element); items stall meanwhile.
// ----------------------------------------------------------------------------
module block_sum_range_query #(
   parameter int DEPTH  = bsrq_pkg::DEF_DEPTH,
   parameter int BLOCKS = bsrq_pkg::DEF_BLOCKS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_kind,
   input  logic        [bsrq_pkg::IDX_W-1:0]  req_index,
   input  logic        [bsrq_pkg::IDX_W-1:0]  req_right_end,
   input  logic signed [bsrq_pkg::VAL_W-1:0]  req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [bsrq_pkg::VAL_W-1:0]  rsp_sum,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic        [bsrq_pkg::LEN_W-1:0]  csr_block_len
);

   import bsrq_pkg::*;

   bsrq_cmd_type    cmd;
   bsrq_status_type status;

   bsrq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bsrq_datapath #(
      .DEPTH  (DEPTH),
      .BLOCKS (BLOCKS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_kind      (req_kind),
      .req_index     (req_index),
      .req_right_end (req_right_end),
      .req_value     (req_value),
      .csr_block_len (csr_block_len),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_sum       (rsp_sum)
   );

endmodule
